@@ src/first_fit_pool_allocator_macros.svh @@
// Shared assertion helpers for the pool allocator checker.
`ifndef FIRST_FIT_POOL_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define FPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fpa_pkg.sv @@
package fpa_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam int unsigned SIZE_W = 17;
  localparam int unsigned ADDR_W = 16;

  // request field positions in s_axis_tdata
  localparam int unsigned IN_OP_LO   = 0;
  localparam int unsigned IN_SIZE_LO = 2;
  localparam int unsigned IN_ADDR_LO = 19;
  localparam int unsigned IN_NONE_LO = 35;

  // result field positions in m_axis_tdata
  localparam int unsigned OUT_STATUS_LO = 0;
  localparam int unsigned OUT_RES_LO    = 2;
  localparam int unsigned OUT_MOVED_LO  = 18;
  localparam int unsigned OUT_CFROM_LO  = 19;
  localparam int unsigned OUT_CLEN_LO   = 35;
  localparam int unsigned OUT_FREE_LO   = 52;

endpackage

@@ src/fpa_seg_mem.sv @@
module fpa_seg_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned IW     = 8,
  parameter int unsigned OW     = 16,
  parameter int unsigned SW     = 17,
  parameter logic [SW-1:0] RST_SZ = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [OW-1:0] woff_i,
  input  logic [SW-1:0] wsz_i,
  input  logic          wfree_i,
  input  logic [IW-1:0] raddr_i,
  output logic [OW-1:0] roff_o,
  output logic [SW-1:0] rsz_o,
  output logic          rfree_o
);

  logic [OW-1:0] off_mem [DEPTH];
  logic [SW-1:0] sz_mem  [DEPTH];
  logic          free_mem[DEPTH];

  logic [OW-1:0] roff_q;
  logic [SW-1:0] rsz_q;
  logic          rfree_q;
  logic          e0_ok_q;
  logic          rd0_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      off_mem[waddr_i]  <= woff_i;
      sz_mem[waddr_i]   <= wsz_i;
      free_mem[waddr_i] <= wfree_i;
    end
    roff_q  <= off_mem[raddr_i];
    rsz_q   <= sz_mem[raddr_i];
    rfree_q <= free_mem[raddr_i];
  end

  // entry 0 reads as the whole free pool until it is first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_ok_q <= 1'b0;
      rd0_q   <= 1'b0;
    end else begin
      rd0_q <= (raddr_i == '0) && !e0_ok_q;
      if (we_i && (waddr_i == '0)) begin
        e0_ok_q <= 1'b1;
      end
    end
  end

  assign roff_o  = rd0_q ? '0 : roff_q;
  assign rsz_o   = rd0_q ? RST_SZ : rsz_q;
  assign rfree_o = rd0_q ? 1'b1 : rfree_q;

endmodule

@@ src/first_fit_pool_allocator.sv @@
// First-fit pool allocator with coalescing.
// Requests enter on s_axis (op, request_size, payload_address, no_address);
// one result per request leaves on m_axis (status, result_address, moved,
// copy_from, copy_length, free_bytes).
// The segment table lives in one synchronous RAM with a registered read.
// A request is worked step by step: every segment visited by the first-fit or
// address search is read, then checked, and every entry moved when a split
// inserts or a merge removes a table entry is read, then written.
// Worst case is a relocating resize: address search, first-fit search, an
// insert for the split and two removes for the merges.
// One request is worked on at a time; s_axis_tready is high only when idle.
// Results sit in an output register, so the next request is taken while a
// result waits; a stalled receiver holds the block only when a second
// result is ready to leave.
// Reset makes the table one free segment spanning the pool and needs no
// clearing pass: entry 0 reads as that segment until first written.
module first_fit_pool_allocator #(
  parameter int unsigned POOL_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_SEGMENTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], request_size[18:2], payload_address[34:19], no_address[35]
  input  logic [fpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], result_address[17:2], moved[18], copy_from[34:19],
  // copy_length[51:35], free_bytes[68:52]
  output logic [fpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned OW = $clog2(POOL_BYTES);
  localparam int unsigned SW = (OW + 1 > 17) ? OW + 1 : 17;
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [SW-1:0] HDR    = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] RST_SZ = SW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] MAXC   = CW'(MAX_SEGMENTS);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_NX_RD, S_NX_GET, S_PV_RD, S_PV_GET,
    S_FREE_APPLY, S_FREE_RM2, S_RS_APPLY, S_RS_W2, S_ALLOC_FIN,
    S_INS_RD, S_INS_WR, S_RM_RD, S_RM_WR, S_DONE
  } state_e;

  state_e state_q, ret_q;

  logic [SW-1:0] size_q;
  logic [15:0]   addr_q;
  logic          is_free_q, alloc_mode_q, mv_q, split_q;
  logic [CW-1:0] k_q, i_q, j_q, at_q, cnt_q;
  logic [SW-1:0] ft_q;
  logic [OW-1:0] cur_off_q, pv_off_q, ins_off_q, hdr_q;
  logic [SW-1:0] cur_sz_q, nx_sz_q, pv_sz_q, ins_sz_q;
  logic          nx_v_q, pv_v_q;
  logic [1:0]    st_q;
  logic [15:0]   res_q, cfrom_q;
  logic [16:0]   clen_q;
  logic          moved_q;
  logic          out_valid_q;
  logic [fpa_pkg::OUT_TDATA_W-1:0] out_data_q;

  // memory port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [OW-1:0] woff, rd_off;
  logic [SW-1:0] wsz, rd_sz;
  logic          wfree, rd_free;

  fpa_seg_mem #(
    .DEPTH  (MAX_SEGMENTS),
    .IW     (IW),
    .OW     (OW),
    .SW     (SW),
    .RST_SZ (RST_SZ)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .woff_i  (woff),
    .wsz_i   (wsz),
    .wfree_i (wfree),
    .raddr_i (raddr),
    .roff_o  (rd_off),
    .rsz_o   (rd_sz),
    .rfree_o (rd_free)
  );

  // scan checks
  logic [SW-1:0] rd_pay, a_rem;
  logic          pay_match, alloc_hit, a_split, has_room;
  assign has_room  = cnt_q < MAXC;
  assign rd_pay    = SW'(rd_off) + HDR;
  assign pay_match = rd_pay[15:0] == addr_q;
  assign alloc_hit = rd_free && (rd_sz >= size_q);
  assign a_rem     = rd_sz - size_q;
  assign a_split   = (a_rem > HDR) && has_room;

  // resize in place
  logic [SW-1:0] rs_rem, rs_tot, rs_rem2, rs_newsz;
  logic [OW-1:0] rs_tail;
  logic          rs_shrink, rs_grow, rs_fit, rs_split, rs_gsplit, rs_we;
  assign rs_shrink = cur_sz_q > size_q;
  assign rs_grow   = cur_sz_q < size_q;
  assign rs_rem    = cur_sz_q - size_q;
  assign rs_tot    = cur_sz_q + HDR + nx_sz_q;
  assign rs_rem2   = rs_tot - size_q;
  assign rs_fit    = nx_v_q && (rs_tot >= size_q);
  assign rs_split  = (rs_rem > HDR) && has_room;
  assign rs_gsplit = rs_rem2 > HDR;
  assign rs_tail   = cur_off_q + OW'(HDR) + OW'(size_q);
  assign rs_newsz  = (rs_grow && rs_fit && !rs_gsplit) ? rs_tot : size_q;
  assign rs_we     = (rs_shrink && (nx_v_q || rs_split)) || (rs_grow && rs_fit);

  // free merge
  logic [SW-1:0] fr_merged;
  assign fr_merged = cur_sz_q + (nx_v_q ? HDR + nx_sz_q : '0);

  logic [CW-1:0] i_inc, i_dec, k_dec, k_inc;
  assign i_inc = i_q + CW'(1);
  assign i_dec = i_q - CW'(1);
  assign k_dec = k_q - CW'(1);
  assign k_inc = k_q + CW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = k_q[IW-1:0];
    woff  = rd_off;
    wsz   = rd_sz;
    wfree = rd_free;
    raddr = k_q[IW-1:0];
    case (state_q)
      S_NX_RD:  raddr = i_inc[IW-1:0];
      S_PV_RD:  raddr = i_dec[IW-1:0];
      S_INS_RD: begin
        raddr = k_dec[IW-1:0];
        if (k_q <= at_q) begin
          we    = 1'b1;
          waddr = at_q[IW-1:0];
          woff  = ins_off_q;
          wsz   = ins_sz_q;
          wfree = 1'b1;
        end
      end
      S_RM_RD:  raddr = k_inc[IW-1:0];
      S_SCAN_CHK: begin
        if (alloc_mode_q && alloc_hit) begin
          we    = 1'b1;
          wsz   = a_split ? size_q : rd_sz;
          wfree = 1'b0;
        end
      end
      S_FREE_APPLY: begin
        we    = 1'b1;
        waddr = pv_v_q ? i_dec[IW-1:0] : i_q[IW-1:0];
        woff  = pv_v_q ? pv_off_q : cur_off_q;
        wsz   = pv_v_q ? pv_sz_q + HDR + fr_merged : fr_merged;
        wfree = 1'b1;
      end
      S_RS_APPLY: begin
        we    = rs_we;
        waddr = i_q[IW-1:0];
        woff  = cur_off_q;
        wsz   = rs_newsz;
        wfree = 1'b0;
      end
      S_RS_W2: begin
        we    = 1'b1;
        waddr = i_inc[IW-1:0];
        woff  = ins_off_q;
        wsz   = ins_sz_q;
        wfree = 1'b1;
      end
      S_INS_WR, S_RM_WR: we = 1'b1;
      default: ;
    endcase
  end

  logic [1:0]  in_op;
  logic [16:0] in_size;
  logic [15:0] in_addr;
  logic        in_none;
  assign in_op   = s_axis_tdata[fpa_pkg::IN_OP_LO +: 2];
  assign in_size = s_axis_tdata[fpa_pkg::IN_SIZE_LO +: 17];
  assign in_addr = s_axis_tdata[fpa_pkg::IN_ADDR_LO +: 16];
  assign in_none = s_axis_tdata[fpa_pkg::IN_NONE_LO];

  logic [15:0] cur_pay, hdr_pay;
  logic [SW-1:0] hdr_pay_w, cur_pay_w;
  assign cur_pay_w = SW'(cur_off_q) + HDR;
  assign hdr_pay_w = SW'(hdr_q) + HDR;
  assign cur_pay   = cur_pay_w[15:0];
  assign hdr_pay   = hdr_pay_w[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      cnt_q        <= CW'(1);
      ft_q         <= RST_SZ;
      out_valid_q  <= 1'b0;
      is_free_q    <= 1'b0;
      alloc_mode_q <= 1'b0;
      mv_q         <= 1'b0;
      split_q      <= 1'b0;
      nx_v_q       <= 1'b0;
      pv_v_q       <= 1'b0;
      k_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      at_q         <= '0;
    end else begin
      // drop a taken result unless a new one is loaded below
      if (m_axis_tready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            size_q    <= SW'(in_size);
            addr_q    <= in_addr;
            st_q      <= fpa_pkg::ST_DONE;
            res_q     <= '0;
            moved_q   <= 1'b0;
            cfrom_q   <= '0;
            clen_q    <= '0;
            mv_q      <= 1'b0;
            k_q       <= '0;
            is_free_q <= in_op == fpa_pkg::OP_FREE;
            if ((in_op == fpa_pkg::OP_ALLOC) ||
                ((in_op == fpa_pkg::OP_RESIZE) && in_none && (in_size != '0))) begin
              alloc_mode_q <= 1'b1;
              state_q      <= S_SCAN_RD;
            end else if ((in_op == fpa_pkg::OP_FREE) ||
                         ((in_op == fpa_pkg::OP_RESIZE) && (in_size != '0))) begin
              alloc_mode_q <= 1'b0;
              state_q      <= S_SCAN_RD;
            end else if (in_op == fpa_pkg::OP_RESIZE) begin
              st_q    <= fpa_pkg::ST_IGNORED;
              res_q   <= in_none ? '0 : in_addr;
              state_q <= S_DONE;
            end else begin
              st_q    <= fpa_pkg::ST_IGNORED;
              state_q <= S_DONE;
            end
          end
        end
        S_SCAN_RD: begin
          if (k_q >= cnt_q) begin
            if (alloc_mode_q) begin
              st_q  <= fpa_pkg::ST_NOFIT;
              res_q <= '0;
            end else begin
              st_q  <= fpa_pkg::ST_IGNORED;
              res_q <= is_free_q ? '0 : addr_q;
            end
            state_q <= S_DONE;
          end else begin
            state_q <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (alloc_mode_q) begin
            if (alloc_hit) begin
              j_q     <= k_q;
              hdr_q   <= rd_off;
              split_q <= a_split;
              if (a_split) begin
                ins_off_q <= rd_off + OW'(HDR) + OW'(size_q);
                ins_sz_q  <= a_rem - HDR;
                ft_q      <= ft_q - HDR - size_q;
                at_q      <= k_inc;
                k_q       <= cnt_q;
                ret_q     <= S_ALLOC_FIN;
                state_q   <= S_INS_RD;
              end else begin
                ft_q    <= ft_q - rd_sz;
                state_q <= S_ALLOC_FIN;
              end
            end else begin
              k_q     <= k_inc;
              state_q <= S_SCAN_RD;
            end
          end else if (pay_match) begin
            if (rd_free) begin
              st_q    <= fpa_pkg::ST_IGNORED;
              res_q   <= is_free_q ? '0 : addr_q;
              state_q <= S_DONE;
            end else begin
              cur_off_q <= rd_off;
              cur_sz_q  <= rd_sz;
              i_q       <= k_q;
              state_q   <= S_NX_RD;
            end
          end else begin
            k_q     <= k_inc;
            state_q <= S_SCAN_RD;
          end
        end
        S_NX_RD: begin
          if (i_inc < cnt_q) begin
            state_q <= S_NX_GET;
          end else begin
            nx_v_q  <= 1'b0;
            nx_sz_q <= '0;
            state_q <= is_free_q ? S_PV_RD : S_RS_APPLY;
          end
        end
        S_NX_GET: begin
          nx_sz_q <= rd_sz;
          nx_v_q  <= rd_free;
          state_q <= is_free_q ? S_PV_RD : S_RS_APPLY;
        end
        S_PV_RD: begin
          if (i_q != '0) begin
            state_q <= S_PV_GET;
          end else begin
            pv_v_q  <= 1'b0;
            state_q <= S_FREE_APPLY;
          end
        end
        S_PV_GET: begin
          pv_off_q <= rd_off;
          pv_sz_q  <= rd_sz;
          pv_v_q   <= rd_free;
          state_q  <= S_FREE_APPLY;
        end
        S_FREE_APPLY: begin
          ft_q <= ft_q + cur_sz_q + (nx_v_q ? HDR : '0) + (pv_v_q ? HDR : '0);
          if (nx_v_q) begin
            at_q    <= i_inc;
            k_q     <= i_inc;
            ret_q   <= S_FREE_RM2;
            state_q <= S_RM_RD;
          end else begin
            state_q <= S_FREE_RM2;
          end
        end
        S_FREE_RM2: begin
          if (pv_v_q) begin
            at_q    <= i_q;
            k_q     <= i_q;
            ret_q   <= S_DONE;
            state_q <= S_RM_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_RS_APPLY: begin
          res_q <= cur_pay;
          if (rs_shrink) begin
            if (nx_v_q) begin
              ins_off_q <= rs_tail;
              ins_sz_q  <= nx_sz_q + rs_rem;
              ft_q      <= ft_q + rs_rem;
              state_q   <= S_RS_W2;
            end else if (rs_split) begin
              ins_off_q <= rs_tail;
              ins_sz_q  <= rs_rem - HDR;
              ft_q      <= ft_q + rs_rem - HDR;
              at_q      <= i_inc;
              k_q       <= cnt_q;
              ret_q     <= S_DONE;
              state_q   <= S_INS_RD;
            end else begin
              state_q <= S_DONE;
            end
          end else if (rs_grow) begin
            if (rs_fit) begin
              if (rs_gsplit) begin
                ins_off_q <= rs_tail;
                ins_sz_q  <= rs_rem2 - HDR;
                ft_q      <= ft_q - nx_sz_q + rs_rem2 - HDR;
                state_q   <= S_RS_W2;
              end else begin
                ft_q    <= ft_q - nx_sz_q;
                at_q    <= i_inc;
                k_q     <= i_inc;
                ret_q   <= S_DONE;
                state_q <= S_RM_RD;
              end
            end else begin
              // relocate: first fit, then free the old block
              mv_q         <= 1'b1;
              alloc_mode_q <= 1'b1;
              k_q          <= '0;
              state_q      <= S_SCAN_RD;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_RS_W2: state_q <= S_DONE;
        S_ALLOC_FIN: begin
          res_q <= hdr_pay;
          if (mv_q) begin
            moved_q   <= 1'b1;
            cfrom_q   <= cur_pay;
            clen_q    <= cur_sz_q[16:0];
            is_free_q <= 1'b1;
            if (split_q && (j_q < i_q)) begin
              i_q <= i_inc;
            end
            state_q <= S_NX_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_INS_RD: begin
          if (k_q > at_q) begin
            state_q <= S_INS_WR;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= ret_q;
          end
        end
        S_INS_WR: begin
          k_q     <= k_dec;
          state_q <= S_INS_RD;
        end
        S_RM_RD: begin
          if (k_inc < cnt_q) begin
            state_q <= S_RM_WR;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= ret_q;
          end
        end
        S_RM_WR: begin
          k_q     <= k_inc;
          state_q <= S_RM_RD;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b000, ft_q[16:0], clen_q, cfrom_q, moved_q, res_q, st_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ src/fpa_checker.sv @@
`include "first_fit_pool_allocator_macros.svh"

module fpa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0]  status;
  logic [15:0] res_addr;
  logic        moved;
  assign status   = m_axis_tdata[fpa_pkg::OUT_STATUS_LO +: 2];
  assign res_addr = m_axis_tdata[fpa_pkg::OUT_RES_LO +: 16];
  assign moved    = m_axis_tdata[fpa_pkg::OUT_MOVED_LO];

  `FPA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `FPA_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  `FPA_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")
  `FPA_ASSERT_SAME(a_moved_done, m_axis_tvalid && moved, status == fpa_pkg::ST_DONE, "move reported with failure status")
  `FPA_ASSERT_SAME(a_nofit_addr, m_axis_tvalid && (status == fpa_pkg::ST_NOFIT), res_addr == '0, "no-fit result carries an address")

endmodule

bind first_fit_pool_allocator fpa_checker u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned POOL   = 65536;
  localparam int unsigned HDR    = 16;
  localparam int unsigned MAXSEG = 256;
  localparam int unsigned DRAIN_CYCLES = 4 * MAXSEG + 40;

  typedef struct packed {
    logic        none;
    logic [15:0] addr;
    logic [16:0] size;
    logic [1:0]  op;
  } pool_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] addr;
    logic        moved;
    logic [15:0] cfrom;
    logic [16:0] clen;
    logic [16:0] free_bytes;
  } pool_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // op[1:0], request_size[18:2], payload_address[34:19], no_address[35]
  logic [fpa_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // status[1:0], result_address[17:2], moved[18], copy_from[34:19],
  // copy_length[51:35], free_bytes[68:52]
  logic [fpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  first_fit_pool_allocator u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #6 clk_i = ~clk_i;

  // shadow segment table
  int unsigned seg_hdr [MAXSEG];
  int unsigned seg_len [MAXSEG];
  bit          seg_is_free [MAXSEG];
  int unsigned seg_num;
  int unsigned free_sum;

  pool_req_t pending_q[$];
  pool_res_t alloc_result_q[$];
  pool_req_t cur_req;
  bit        req_taken;
  bit        calm;
  bit        rx_hold_kick;
  int unsigned rx_hold_left;
  int unsigned errors;
  int unsigned n_req, n_res, n_moved, n_nofit, n_ignored;

  function automatic void seg_insert(int unsigned at, int unsigned o, int unsigned s, bit f);
    if (seg_num >= MAXSEG || at > seg_num) return;
    for (int unsigned k = seg_num; k > at; k--) begin
      seg_hdr[k] = seg_hdr[k-1];
      seg_len[k] = seg_len[k-1];
      seg_is_free[k] = seg_is_free[k-1];
    end
    seg_hdr[at] = o;
    seg_len[at] = s;
    seg_is_free[at] = f;
    seg_num++;
  endfunction

  function automatic void seg_delete(int unsigned at);
    if (at >= seg_num) return;
    for (int unsigned k = at; k + 1 < seg_num; k++) begin
      seg_hdr[k] = seg_hdr[k+1];
      seg_len[k] = seg_len[k+1];
      seg_is_free[k] = seg_is_free[k+1];
    end
    seg_num--;
  endfunction

  function automatic int unsigned seg_by_payload(int unsigned a);
    for (int unsigned i = 0; i < seg_num; i++)
      if (((seg_hdr[i] + HDR) & 16'hFFFF) == a) return i;
    return seg_num;
  endfunction

  function automatic bit take_first_fit(int unsigned sz, output int unsigned hdr);
    int unsigned rem;
    hdr = 0;
    for (int unsigned i = 0; i < seg_num; i++) begin
      if (seg_is_free[i] && seg_len[i] >= sz) begin
        seg_is_free[i] = 1'b0;
        rem = seg_len[i] - sz;
        if (rem > HDR && seg_num < MAXSEG) begin
          seg_len[i] = sz;
          seg_insert(i + 1, seg_hdr[i] + HDR + sz, rem - HDR, 1'b1);
          free_sum -= HDR;
        end
        free_sum -= seg_len[i];
        hdr = seg_hdr[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void release_seg(int unsigned i);
    int unsigned gain;
    gain = seg_len[i];
    seg_is_free[i] = 1'b1;
    if (i + 1 < seg_num && seg_is_free[i+1]) begin
      seg_len[i] += HDR + seg_len[i+1];
      seg_delete(i + 1);
      gain += HDR;
    end
    if (i > 0 && seg_is_free[i-1]) begin
      seg_len[i-1] += HDR + seg_len[i];
      seg_delete(i);
      gain += HDR;
    end
    free_sum += gain;
  endfunction

  function automatic pool_res_t pool_step(pool_req_t r);
    pool_res_t   o;
    int unsigned sz, a, i, b, rem, total, hdr, old_hdr;
    bit          nx;
    sz = r.size;
    a = r.addr;
    o.status = fpa_pkg::ST_DONE;
    o.addr = '0;
    o.moved = 1'b0;
    o.cfrom = '0;
    o.clen = '0;
    if (r.op == fpa_pkg::OP_ALLOC || (r.op == fpa_pkg::OP_RESIZE && r.none && sz != 0)) begin
      if (take_first_fit(sz, hdr)) o.addr = hdr + HDR;
      else o.status = fpa_pkg::ST_NOFIT;
    end else if (r.op == fpa_pkg::OP_FREE) begin
      i = seg_by_payload(a);
      if (i >= seg_num || seg_is_free[i]) o.status = fpa_pkg::ST_IGNORED;
      else release_seg(i);
    end else if (r.op == fpa_pkg::OP_RESIZE && sz == 0) begin
      o.status = fpa_pkg::ST_IGNORED;
      o.addr = r.none ? 16'd0 : r.addr;
    end else if (r.op == fpa_pkg::OP_RESIZE) begin
      i = seg_by_payload(a);
      if (i >= seg_num || seg_is_free[i]) begin
        o.status = fpa_pkg::ST_IGNORED;
        o.addr = r.addr;
      end else begin
        b = seg_len[i];
        o.addr = seg_hdr[i] + HDR;
        nx = (i + 1 < seg_num) && seg_is_free[i+1];
        if (b > sz) begin
          if (nx) begin
            // shrink: the freed tail joins the free successor
            seg_len[i] = sz;
            seg_hdr[i+1] = seg_hdr[i] + HDR + sz;
            seg_len[i+1] += b - sz;
            free_sum += b - sz;
          end else begin
            rem = b - sz;
            if (rem > HDR && seg_num < MAXSEG) begin
              seg_len[i] = sz;
              seg_insert(i + 1, seg_hdr[i] + HDR + sz, rem - HDR, 1'b1);
              free_sum += rem - HDR;
            end
          end
        end else if (b < sz) begin
          total = nx ? b + HDR + seg_len[i+1] : 0;
          if (nx && total >= sz) begin
            rem = total - sz;
            free_sum -= seg_len[i+1];
            if (rem > HDR) begin
              seg_len[i] = sz;
              seg_hdr[i+1] = seg_hdr[i] + HDR + sz;
              seg_len[i+1] = rem - HDR;
              free_sum += rem - HDR;
            end else begin
              seg_len[i] = total;
              seg_delete(i + 1);
            end
          end else begin
            old_hdr = seg_hdr[i];
            if (take_first_fit(sz, hdr)) begin
              for (i = 0; i < seg_num; i++)
                if (seg_hdr[i] == old_hdr) break;
              if (i < seg_num) release_seg(i);
              o.moved = 1'b1;
              o.cfrom = o.addr;
              o.clen = b;
              o.addr = hdr + HDR;
            end else begin
              o.status = fpa_pkg::ST_NOFIT;
              o.addr = '0;
            end
          end
        end
      end
    end else begin
      o.status = fpa_pkg::ST_IGNORED;
    end
    o.free_bytes = free_sum;
    return o;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h", n_res, field, got, want);
    errors++;
  endtask

  // request side
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
        cur_req = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= fpa_pkg::IN_TDATA_W'(cur_req);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side, with a long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_kick) begin
        rx_hold_kick = 1'b0;
        rx_hold_left = 3000;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(0, 99) >= 25;
      end
    end
  end

  always @(posedge clk_i) begin
    pool_res_t want;
    pool_res_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = m_axis_tdata[fpa_pkg::OUT_STATUS_LO +: 2];
        got.addr       = m_axis_tdata[fpa_pkg::OUT_RES_LO +: 16];
        got.moved      = m_axis_tdata[fpa_pkg::OUT_MOVED_LO];
        got.cfrom      = m_axis_tdata[fpa_pkg::OUT_CFROM_LO +: 16];
        got.clen       = m_axis_tdata[fpa_pkg::OUT_CLEN_LO +: 17];
        got.free_bytes = m_axis_tdata[fpa_pkg::OUT_FREE_LO +: 17];
        if (alloc_result_q.size() == 0) begin
          $display("result with nothing outstanding: 0x%0h", m_axis_tdata);
          errors++;
        end else begin
          want = alloc_result_q.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.addr != want.addr) report_mismatch("result_address", got.addr, want.addr);
          if (got.moved != want.moved) report_mismatch("moved", got.moved, want.moved);
          if (got.cfrom != want.cfrom) report_mismatch("copy_from", got.cfrom, want.cfrom);
          if (got.clen != want.clen) report_mismatch("copy_length", got.clen, want.clen);
          if (got.free_bytes != want.free_bytes)
            report_mismatch("free_bytes", got.free_bytes, want.free_bytes);
          if (want.moved) n_moved++;
          if (want.status == fpa_pkg::ST_NOFIT) n_nofit++;
          if (want.status == fpa_pkg::ST_IGNORED) n_ignored++;
        end
        n_res++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        alloc_result_q.push_back(pool_step(cur_req));
        req_taken = 1'b1;
        n_req++;
      end
    end
  end

  task automatic send(logic [1:0] op, int unsigned sz, int unsigned a, bit none);
    pool_req_t r;
    while (pending_q.size() > 1) @(posedge clk_i);
    r.op = op;
    r.size = sz;
    r.addr = a;
    r.none = none;
    pending_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || s_axis_tvalid || alloc_result_q.size() > 0)
      @(posedge clk_i);
  endtask

  // payload address of a random used (or, with want_free, free) segment
  function automatic int unsigned pick_payload(bit want_free);
    int unsigned start;
    start = $urandom_range(0, seg_num - 1);
    for (int unsigned k = 0; k < seg_num; k++) begin
      int unsigned j;
      j = (start + k) % seg_num;
      if (seg_is_free[j] == want_free) return (seg_hdr[j] + HDR) & 16'hFFFF;
    end
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned rand_size();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 8) return $urandom_range(0, 24);
    if (p < 92) return $urandom_range(1, 700);
    if (p < 97) return $urandom_range(700, 20000);
    return $urandom_range(20000, 65536);
  endfunction

  task automatic random_item();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 42) send(fpa_pkg::OP_ALLOC, rand_size(), $urandom_range(0, 65535),
                     $urandom_range(0, 1));
    else if (p < 70) send(fpa_pkg::OP_FREE, 0, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 65535) : pick_payload($urandom_range(0, 19) == 0),
                          $urandom_range(0, 1));
    else if (p < 93) begin
      if ($urandom_range(0, 9) == 0)
        send(fpa_pkg::OP_RESIZE, rand_size(), $urandom_range(0, 65535), 1'b1);
      else send(fpa_pkg::OP_RESIZE, ($urandom_range(0, 19) == 0) ? 0 : rand_size(),
                pick_payload($urandom_range(0, 19) == 0), 1'b0);
    end else if (p < 97) send(2'd3, $urandom_range(0, 131071), $urandom_range(0, 65535),
                             $urandom_range(0, 1));
    else send(fpa_pkg::OP_RESIZE, $urandom_range(0, 131071) & 17'h1FFFF,
              $urandom_range(0, 65535), $urandom_range(0, 1));
  endtask

  initial begin
    seg_num = 1;
    seg_hdr[0] = 0;
    seg_len[0] = POOL - HDR;
    seg_is_free[0] = 1'b1;
    free_sum = POOL - HDR;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes and corner cases
    calm = 1'b1;
    send(fpa_pkg::OP_ALLOC, 0, 0, 1'b0);
    send(fpa_pkg::OP_ALLOC, 65536, 16'hFFFF, 1'b0);
    send(fpa_pkg::OP_ALLOC, 100, 0, 1'b0);
    send(fpa_pkg::OP_ALLOC, 200, 0, 1'b0);
    send(fpa_pkg::OP_ALLOC, 300, 0, 1'b0);
    send(fpa_pkg::OP_ALLOC, 40, 0, 1'b0);
    wait_idle();
    send(fpa_pkg::OP_FREE, 0, seg_hdr[2] + HDR, 1'b0);
    wait_idle();
    send(fpa_pkg::OP_FREE, 0, seg_hdr[2] + HDR, 1'b0);
    send(fpa_pkg::OP_RESIZE, 60, seg_hdr[1] + HDR, 1'b0);
    send(fpa_pkg::OP_RESIZE, 60, seg_hdr[1] + HDR, 1'b0);
    send(fpa_pkg::OP_FREE, 0, 16'h1234, 1'b0);
    send(fpa_pkg::OP_FREE, 0, 16'hFFFF, 1'b1);
    wait_idle();
    send(fpa_pkg::OP_RESIZE, 10, seg_hdr[seg_num-2] + HDR, 1'b0);
    send(fpa_pkg::OP_RESIZE, 0, seg_hdr[1] + HDR, 1'b0);
    send(fpa_pkg::OP_RESIZE, 0, 16'hABCD, 1'b1);
    send(fpa_pkg::OP_RESIZE, 64, 0, 1'b1);
    send(2'd3, 17'h1FFFF, 16'hFFFF, 1'b1);
    wait_idle();
    send(fpa_pkg::OP_RESIZE, 5000, pick_payload(1'b0), 1'b0);
    send(fpa_pkg::OP_RESIZE, 65536, pick_payload(1'b0), 1'b0);
    send(fpa_pkg::OP_RESIZE, 1, seg_hdr[0] + HDR, 1'b0);
    send(fpa_pkg::OP_ALLOC, 65536 - HDR, 0, 1'b0);
    wait_idle();
    calm = 1'b0;

    for (int n = 0; n < 940; n++) begin
      if (n == 150) begin
        // fill the table with tiny requests
        for (int k = 0; k < 90; k++) send(fpa_pkg::OP_ALLOC, $urandom_range(0, 12), 0, 1'b0);
      end
      if (n == 300) begin
        wait_idle();
        rx_hold_kick = 1'b1;
      end
      if (n == 500) wait_idle();
      calm = (n >= 600 && n < 720);
      random_item();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests: %0d moved resizes, %0d no-fit, %0d ignored",
             n_req, n_moved, n_nofit, n_ignored);
    $display("segments in use at end: %0d, free payload bytes %0d", seg_num, free_sum);
    if (errors == 0 && alloc_result_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #72_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ first_fit_pool_allocator.f @@
+incdir+src
src/fpa_pkg.sv
src/fpa_seg_mem.sv
src/first_fit_pool_allocator.sv
src/fpa_checker.sv
dv/tb_top.sv
